// ===== hw/rtl/aabb_all_pairs_collision_unit_defines.svh =====
// Assertion macros shared by the collision unit RTL.
`ifndef AABB_ALL_PAIRS_COLLISION_UNIT_DEFINES_SVH
`define AABB_ALL_PAIRS_COLLISION_UNIT_DEFINES_SVH

// Concurrent check of a condition on every edge, off during reset.
`define AAPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition on one edge implies a consequence on the next edge.
`define AAPC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/aapc_pkg.sv =====
// Package: widths, codes, slot entry layout and controller types.
package aapc_pkg;

	localparam int unsigned MAX_SLOTS    = 8;
	localparam int unsigned SLOT_FIELD_W = 3;
	localparam int unsigned ID_W         = 16;
	localparam int unsigned COORD_W      = 16;
	localparam int unsigned MASK_W       = 8;

	// command field codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SWEEP = 1'b1;

	// one stored slot: identifier plus rectangle edges
	typedef struct packed {
		logic        [ID_W-1:0]    id;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] left;
	} slot_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // write the slot carried by the accepted word
		logic start;   // accepted sweep: rewind pair counter, clear pending hit
		logic step;    // advance compare stage
		logic issue;   // with step: read the next pair into the compare stage
		logic finish;  // emit the closing result word
	} aapc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_pair;  // pair counter sits on the final ordered pair
		logic out_free;   // output register can take a word this cycle
	} aapc_sts_t;

endpackage

// ===== hw/rtl/aapc_in_if.sv =====
// Input word channel: load or sweep commands.
interface aapc_in_if;
	import aapc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [SLOT_FIELD_W-1:0]    slot;
	logic [ID_W-1:0]            collider_id;
	logic                       active;
	logic signed [COORD_W-1:0]  left;
	logic signed [COORD_W-1:0]  right;
	logic signed [COORD_W-1:0]  top;
	logic signed [COORD_W-1:0]  bottom;

	modport source (output valid, command, slot, collider_id, active, left, right, top, bottom,
		input ready);
	modport sink (input valid, command, slot, collider_id, active, left, right, top, bottom,
		output ready);
endinterface

// ===== hw/rtl/aapc_out_if.sv =====
// Result word channel: reported pairs.
interface aapc_out_if;
	import aapc_pkg::*;

	logic            valid;
	logic            ready;
	logic            hit;
	logic [ID_W-1:0] first_id;
	logic [ID_W-1:0] second_id;
	logic            last;

	modport source (output valid, hit, first_id, second_id, last, input ready);
	modport sink (input valid, hit, first_id, second_id, last, output ready);
endinterface

// ===== hw/rtl/aapc_cfg_if.sv =====
// Configuration write channel: exclusion mask.
interface aapc_cfg_if;
	import aapc_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/aapc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module aapc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/aapc_ctrl.sv =====
// Sequencer: accepts words, walks the sweep phases, drives datapath commands.
`include "aabb_all_pairs_collision_unit_defines.svh"

module aapc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_command,
	output logic               in_ready,
	input  aapc_pkg::aapc_sts_t sts_i,
	output aapc_pkg::aapc_cmd_t cmd_o
);
	import aapc_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd_o     = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_command == CMD_SWEEP) begin
						cmd_o.start = 1'b1;
						state_nxt   = ST_SWEEP;
					end else begin
						cmd_o.load = 1'b1;
					end
				end
			end
			ST_SWEEP: begin
				if (sts_i.out_free) begin
					cmd_o.step  = 1'b1;
					cmd_o.issue = 1'b1;
					if (sts_i.last_pair) begin
						state_nxt = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				// retire the final pair still in the compare stage
				if (sts_i.out_free) begin
					cmd_o.step = 1'b1;
					state_nxt  = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts_i.out_free) begin
					cmd_o.finish = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	`AAPC_ASSERT(a_adv_needs_room, (!(cmd_o.step || cmd_o.finish)) || sts_i.out_free, "advance without output room")
	`AAPC_ASSERT_NEXT(a_last_to_drain, state_q == ST_SWEEP && cmd_o.step && sts_i.last_pair, state_q == ST_DRAIN, "sweep did not drain after last pair")
	`AAPC_ASSERT_NEXT(a_start_to_sweep, cmd_o.start, state_q == ST_SWEEP && !in_ready, "sweep start not followed by sweep phase")
endmodule

// ===== hw/rtl/aapc_dp.sv =====
// Datapath: slot stores, pair counter, compare stage, pending hit and output register.
`include "aabb_all_pairs_collision_unit_defines.svh"

module aapc_dp #(
	parameter int unsigned SLOTS = aapc_pkg::MAX_SLOTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  aapc_pkg::aapc_cmd_t                  cmd_i,
	output aapc_pkg::aapc_sts_t                  sts_o,
	// load payload
	input  logic [aapc_pkg::SLOT_FIELD_W-1:0]    slot,
	input  logic [aapc_pkg::ID_W-1:0]            collider_id,
	input  logic                                 active,
	input  logic signed [aapc_pkg::COORD_W-1:0]  left,
	input  logic signed [aapc_pkg::COORD_W-1:0]  right,
	input  logic signed [aapc_pkg::COORD_W-1:0]  top,
	input  logic signed [aapc_pkg::COORD_W-1:0]  bottom,
	// mask write
	input  logic                                 cfg_we,
	input  logic [aapc_pkg::MASK_W-1:0]          cfg_data,
	// result register
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic                                 out_hit,
	output logic [aapc_pkg::ID_W-1:0]            out_first_id,
	output logic [aapc_pkg::ID_W-1:0]            out_second_id,
	output logic                                 out_last
);
	import aapc_pkg::*;

	localparam int unsigned IDX_W  = $clog2(SLOTS);
	localparam int unsigned SL_W   = SLOT_FIELD_W + 1;
	localparam int unsigned ENT_W  = $bits(slot_entry_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [IDX_W-1:0] PREV_IDX = IDX_W'(SLOTS - 2);

	logic [SLOTS-1:0] active_q;
	logic [SLOTS-1:0] mask_q;
	logic [IDX_W-1:0] a_q, b_q, a_nxt, b_nxt, b_tmp;
	logic             v_s1, ok_s1;
	logic             pend_v_q;
	logic [ID_W-1:0]  pend_first_q, pend_second_q;
	logic             out_valid_q, out_hit_q, out_last_q;
	logic [ID_W-1:0]  out_first_q, out_second_q;

	logic             slot_ok, we;
	logic [SLOTS-1:0] part;
	slot_entry_t      wr_ent, ent_a, ent_b;
	logic [ENT_W-1:0] rd_a, rd_b;
	logic             overlap, hit_now;
	logic             out_load;

	assign slot_ok = ({1'b0, slot} < SL_W'(SLOTS));
	assign we      = cmd_i.load && slot_ok;

	assign wr_ent.id     = collider_id;
	assign wr_ent.left   = left;
	assign wr_ent.right  = right;
	assign wr_ent.top    = top;
	assign wr_ent.bottom = bottom;

	// two copies so both sides of a pair read in the same cycle
	aapc_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (slot[IDX_W-1:0]),
		.wdata (wr_ent),
		.re    (cmd_i.step && cmd_i.issue),
		.raddr (a_q),
		.rdata (rd_a)
	);

	aapc_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (slot[IDX_W-1:0]),
		.wdata (wr_ent),
		.re    (cmd_i.step && cmd_i.issue),
		.raddr (b_q),
		.rdata (rd_b)
	);

	assign ent_a = rd_a;
	assign ent_b = rd_b;

	assign part = active_q & ~mask_q;

	// strict on every edge: touching rectangles do not overlap
	assign overlap = (ent_a.left < ent_b.right) && (ent_a.right > ent_b.left) &&
		(ent_a.top < ent_b.bottom) && (ent_a.bottom > ent_b.top);
	assign hit_now = v_s1 && ok_s1 && overlap;

	// next ordered pair, row-major, diagonal skipped
	always_comb begin
		a_nxt = a_q;
		b_tmp = b_q + 1'b1;
		if (b_q == LAST_IDX) begin
			b_tmp = '0;
			a_nxt = a_q + 1'b1;
		end
		b_nxt = b_tmp;
		if (b_tmp == a_nxt) begin
			b_nxt = (b_tmp == LAST_IDX) ? '0 : b_tmp + 1'b1;
		end
	end

	assign sts_o.last_pair = (a_q == LAST_IDX) && (b_q == PREV_IDX);
	assign sts_o.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			mask_q   <= '0;
			a_q      <= '0;
			b_q      <= IDX_W'(1);
			v_s1     <= 1'b0;
			ok_s1    <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_data[SLOTS-1:0];
			end
			if (we) begin
				active_q[slot[IDX_W-1:0]] <= active;
			end
			if (cmd_i.start) begin
				a_q      <= '0;
				b_q      <= IDX_W'(1);
				pend_v_q <= 1'b0;
			end
			if (cmd_i.step) begin
				v_s1  <= cmd_i.issue;
				ok_s1 <= part[a_q] && part[b_q];
				if (cmd_i.issue) begin
					a_q <= a_nxt;
					b_q <= b_nxt;
				end
				if (hit_now) begin
					pend_v_q <= 1'b1;
				end
			end
			if (cmd_i.finish) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.step && hit_now) begin
			pend_first_q  <= ent_a.id;
			pend_second_q <= ent_b.id;
		end
	end

	// output register; the older hit moves out when a newer one arrives
	assign out_load = cmd_i.finish || (cmd_i.step && hit_now && pend_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.finish) begin
			out_hit_q    <= pend_v_q;
			out_first_q  <= pend_v_q ? pend_first_q : '0;
			out_second_q <= pend_v_q ? pend_second_q : '0;
			out_last_q   <= 1'b1;
		end else if (cmd_i.step && hit_now && pend_v_q) begin
			out_hit_q    <= 1'b1;
			out_first_q  <= pend_first_q;
			out_second_q <= pend_second_q;
			out_last_q   <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_hit       = out_hit_q;
	assign out_first_id  = out_first_q;
	assign out_second_id = out_second_q;
	assign out_last      = out_last_q;

	`AAPC_ASSERT(a_no_diagonal, (!(cmd_i.step && cmd_i.issue)) || (a_q != b_q), "pair counter on diagonal")
	`AAPC_ASSERT_NEXT(a_finish_last, cmd_i.finish, out_valid_q && out_last_q, "closing word not marked last")
	`AAPC_ASSERT(a_pend_from_hit, (!$rose(pend_v_q)) || $past(cmd_i.step && hit_now), "pending hit set without a hit")
endmodule

// ===== hw/rtl/aabb_all_pairs_collision_unit.sv =====
// Top level of the all-pairs rectangle collision unit.
//
// The unit holds SLOTS collider slots (identifier, active flag, rectangle).
// A load word (command 0) writes one slot and yields no result; loads to
// a slot at or beyond SLOTS are dropped. A sweep word
// (command 1) compares every ordered pair of distinct slots that are active
// and not excluded by the mask register, row-major from slot 0, and returns
// one word per overlapping pair (first_id hit second_id). Overlap is strict
// on all four sides, so rectangles that only touch are not reported. The
// final word of a sweep carries last; a sweep with no overlap returns one
// word with hit clear, zero identifiers and last set.
// Timing: one shared comparator sees one pair per cycle while the output
// register can take a word; a stalled result side holds the sweep. The
// input is taken again only once the closing word sits in the output
// register. The slot store is duplicated in two small RAMs so both
// rectangles of a pair read in the same cycle; the read data is
// registered ahead of the compare. The mask may be written at any time the
// unit is idle; the write takes effect on the next sweep.
module aabb_all_pairs_collision_unit #(
	parameter int unsigned SLOTS = aapc_pkg::MAX_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	aapc_in_if.sink     req,
	aapc_out_if.source  rsp,
	aapc_cfg_if.sink    cfg
);
	import aapc_pkg::*;

	aapc_cmd_t cmd;
	aapc_sts_t sts;

	// mask register always takes a write
	assign cfg.ready = 1'b1;

	aapc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_command (req.command),
		.in_ready   (req.ready),
		.sts_i      (sts),
		.cmd_o      (cmd)
	);

	aapc_dp #(.SLOTS(SLOTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_i         (cmd),
		.sts_o         (sts),
		.slot          (req.slot),
		.collider_id   (req.collider_id),
		.active        (req.active),
		.left          (req.left),
		.right         (req.right),
		.top           (req.top),
		.bottom        (req.bottom),
		.cfg_we        (cfg.valid),
		.cfg_data      (cfg.data),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_hit       (rsp.hit),
		.out_first_id  (rsp.first_id),
		.out_second_id (rsp.second_id),
		.out_last      (rsp.last)
	);
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the all-pairs rectangle collision unit.
module testbench;
	import aapc_pkg::*;

	// One input word as the sender sees it.
	typedef struct packed {
		logic                      command;
		logic [SLOT_FIELD_W-1:0]   slot;
		logic [ID_W-1:0]           collider_id;
		logic                      active;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] bottom;
	} req_word_t;

	// One result word: a reported pair or the closing word of an empty sweep.
	typedef struct packed {
		logic            hit;
		logic [ID_W-1:0] first_id;
		logic [ID_W-1:0] second_id;
		logic            last;
	} pair_result_t;

	// Shadow slot table plus the queue of pair reports still owed by the unit.
	class collision_scoreboard;
		slot_entry_t          slot_table [MAX_SLOTS];
		logic [MAX_SLOTS-1:0] active_bits;
		logic [MASK_W-1:0]    excluded;
		pair_result_t         pending_pairs [$];
		int unsigned          failures;

		function new();
			active_bits = '0;
			excluded    = '0;
			failures    = 0;
		endfunction

		function void set_mask(logic [MASK_W-1:0] m);
			excluded = m;
		endfunction

		function bit in_sweep(int s);
			return active_bits[s] && !excluded[s];
		endfunction

		// strict on all four edges: touching rectangles do not count
		function bit rects_overlap(slot_entry_t a, slot_entry_t b);
			return $signed(a.left) < $signed(b.right) && $signed(a.right) > $signed(b.left) &&
				$signed(a.top) < $signed(b.bottom) && $signed(a.bottom) > $signed(b.top);
		endfunction

		// Called on every accepted input word.
		function void note_word(req_word_t w);
			slot_entry_t  e;
			pair_result_t r;
			pair_result_t sweep_out [$];
			if (w.command == CMD_LOAD) begin
				if (w.slot < MAX_SLOTS) begin
					e.id     = w.collider_id;
					e.left   = w.left;
					e.right  = w.right;
					e.top    = w.top;
					e.bottom = w.bottom;
					slot_table[w.slot]  = e;
					active_bits[w.slot] = w.active;
				end
				return;
			end
			// row-major over ordered pairs, first slot outer
			for (int a = 0; a < MAX_SLOTS; a++) begin
				for (int b = 0; b < MAX_SLOTS; b++) begin
					if (a != b && in_sweep(a) && in_sweep(b) &&
							rects_overlap(slot_table[a], slot_table[b])) begin
						r.hit       = 1'b1;
						r.first_id  = slot_table[a].id;
						r.second_id = slot_table[b].id;
						r.last      = 1'b0;
						sweep_out.push_back(r);
					end
				end
			end
			if (sweep_out.size() == 0) begin
				r = '0;
				r.last = 1'b1;
				sweep_out.push_back(r);
			end else begin
				sweep_out[sweep_out.size()-1].last = 1'b1;
			end
			foreach (sweep_out[i]) pending_pairs.push_back(sweep_out[i]);
		endfunction

		function void compare_field(string name, logic [ID_W-1:0] exp_v, logic [ID_W-1:0] got_v);
			if (got_v !== exp_v) begin
				$display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, got_v);
				failures++;
			end
		endfunction

		// Called on every accepted result word.
		function void check_result(pair_result_t got);
			pair_result_t exp_r;
			if (pending_pairs.size() == 0) begin
				$display("%0t unexpected word: expected none actual hit=%0b first=%h second=%h last=%0b",
					$time, got.hit, got.first_id, got.second_id, got.last);
				failures++;
				return;
			end
			exp_r = pending_pairs.pop_front();
			compare_field("hit", ID_W'(exp_r.hit), ID_W'(got.hit));
			compare_field("first_id", exp_r.first_id, got.first_id);
			compare_field("second_id", exp_r.second_id, got.second_id);
			compare_field("last", ID_W'(exp_r.last), ID_W'(got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	aapc_in_if  req_ch ();
	aapc_out_if rsp_ch ();
	aapc_cfg_if cfg_ch ();

	aabb_all_pairs_collision_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	collision_scoreboard board;

	// idle knobs, percent of cycles; changed between phases only
	int send_idle_pct;
	int stall_pct;
	// long receiver hold-off, requested by the stimulus and counted by the receiver
	bit hold_request;
	int hold_left;
	int phase_words;
	pair_result_t seen;

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case the unit hangs.
	initial begin
		#(4 * 1_000_000);
		$display("status: fail");
		$finish;
	end

	// Receiver: check each accepted word, then pick ready for the next edge.
	// Sampling right after the edge sees pre-edge values of the unit's outputs.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen.hit       = rsp_ch.hit;
			seen.first_id  = rsp_ch.first_id;
			seen.second_id = rsp_ch.second_id;
			seen.last      = rsp_ch.last;
			board.check_result(seen);
		end
		if (hold_request) begin
			hold_left    = 300;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic signed [COORD_W-1:0] clamp16(int v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[COORD_W-1:0];
	endfunction

	function automatic req_word_t make_load(int s, logic [ID_W-1:0] id, logic act,
			int l, int r, int t, int b);
		req_word_t w;
		w.command     = CMD_LOAD;
		w.slot        = SLOT_FIELD_W'(s);
		w.collider_id = id;
		w.active      = act;
		w.left        = clamp16(l);
		w.right       = clamp16(r);
		w.top         = clamp16(t);
		w.bottom      = clamp16(b);
		return w;
	endfunction

	function automatic req_word_t make_sweep();
		req_word_t w;
		w = '0;
		w.command = CMD_SWEEP;
		return w;
	endfunction

	// Cluster center: near the origin half the time, otherwise pinned at either extreme
	// so the signed compare sees the wrap-prone corners.
	function automatic int pick_center();
		case ($urandom_range(3))
			0: return -32768 + int'($urandom_range(40));
			1: return 32767 - int'($urandom_range(40));
			default: return int'($urandom_range(200)) - 100;
		endcase
	endfunction

	// Offer one word; returns at the edge that accepted it with valid still high.
	// valid only drops inside a gap, so it never gets two updates in one step.
	task automatic send_word(input req_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= w.command;
		req_ch.slot        <= w.slot;
		req_ch.collider_id <= w.collider_id;
		req_ch.active      <= w.active;
		req_ch.left        <= w.left;
		req_ch.right       <= w.right;
		req_ch.top         <= w.top;
		req_ch.bottom      <= w.bottom;
		do @(posedge clk); while (!req_ch.ready);
		board.note_word(w);
		phase_words++;
	endtask

	// Let every owed word come back, then allow the last load to settle.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (board.pending_pairs.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] m);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		board.set_mask(m);
	endtask

	// A well-formed burst: a few loads with rectangles on a 10-pixel grid around
	// one center (so overlaps and touching edges both show up), then a sweep.
	task automatic send_cluster(input int n, input bit fill);
		int cx;
		int cy;
		int l;
		int t;
		req_word_t w;
		cx = pick_center();
		cy = pick_center();
		for (int i = 0; i < n; i++) begin
			l = cx + 10 * int'($urandom_range(6)) - 30;
			t = cy + 10 * int'($urandom_range(6)) - 30;
			w = make_load(fill ? i : int'($urandom_range(7)), ID_W'($urandom),
				fill || ($urandom_range(99) < 85),
				l, l + 10 * int'($urandom_range(4)), t, t + 10 * int'($urandom_range(4)));
			send_word(w);
		end
		send_word(make_sweep());
	endtask

	// Noise: every field random, full range, either command.
	task automatic send_noise();
		req_word_t w;
		w.command     = 1'($urandom);
		w.slot        = SLOT_FIELD_W'($urandom);
		w.collider_id = ID_W'($urandom);
		w.active      = 1'($urandom);
		w.left        = COORD_W'($urandom);
		w.right       = COORD_W'($urandom);
		w.top         = COORD_W'($urandom);
		w.bottom      = COORD_W'($urandom);
		send_word(w);
	endtask

	task automatic random_phase(input int count, input int idle_s, input int idle_r,
			input logic [MASK_W-1:0] m, input bit pressure);
		wait_idle();
		write_mask(m);
		send_idle_pct = idle_s;
		stall_pct     = idle_r;
		phase_words   = 0;
		if (pressure) begin
			// hold the result side while a full-table sweep and more words queue up
			hold_request = 1'b1;
			send_cluster(MAX_SLOTS, 1'b1);
			send_word(make_sweep());
			send_noise();
		end
		while (phase_words < count) begin
			if ($urandom_range(99) < 20) send_noise();
			else send_cluster(int'($urandom_range(6, 1)), 1'b0);
		end
	endtask

	initial begin
		board = new();
		arst_n            = 1'b0;
		hold_request      = 1'b0;
		hold_left         = 0;
		send_idle_pct     = 0;
		stall_pct         = 0;
		phase_words       = 0;
		req_ch.valid      = 1'b0;
		req_ch.command    = CMD_LOAD;
		req_ch.slot       = '0;
		req_ch.collider_id = '0;
		req_ch.active     = 1'b0;
		req_ch.left       = '0;
		req_ch.right      = '0;
		req_ch.top        = '0;
		req_ch.bottom     = '0;
		rsp_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling.
		write_mask(8'h00);
		// nothing active yet: empty sweep
		send_word(make_sweep());
		// full-range rectangle with extreme ids, a small box, and one that only
		// touches it on the x edge, plus an inactive slot on top of the box
		send_word(make_load(0, 16'h0000, 1'b1, -32768, 32767, -32768, 32767));
		send_word(make_load(1, 16'hffff, 1'b1, 0, 10, 0, 10));
		send_word(make_load(2, 16'h1234, 1'b1, 10, 20, 0, 10));
		send_word(make_load(3, 16'habcd, 1'b0, 0, 10, 0, 10));
		send_word(make_sweep());
		// touches slot 1 and slot 2 on the y edge only
		send_word(make_load(4, 16'h5a5a, 1'b1, 5, 15, 10, 20));
		send_word(make_sweep());
		// drop the big one: nothing left overlaps, so the sweep is empty
		send_word(make_load(0, 16'h0000, 1'b0, -32768, 32767, -32768, 32767));
		send_word(make_sweep());
		// every slot overlapping every other: the longest sweep
		for (int s = 0; s < MAX_SLOTS; s++)
			send_word(make_load(s, ID_W'(16'h0101 * (s + 1)), 1'b1,
				-32768, 32767, -32768, 32767));
		send_word(make_sweep());
		// mask extremes and a mixed mask on the full table
		wait_idle();
		write_mask(8'hff);
		send_word(make_sweep());
		wait_idle();
		write_mask(8'h5a);
		send_word(make_sweep());

		// Random part: idling profiles per phase, mask rewritten in between.
		random_phase(20, 0, 0, 8'h00, 1'b0);
		random_phase(20, 88, 0, MASK_W'($urandom_range(255)), 1'b0);
		random_phase(20, 0, 88, 8'h00, 1'b1);
		random_phase(20, 30, 30, MASK_W'($urandom_range(255)), 1'b0);

		// Drain and let any stray word show up.
		req_ch.valid <= 1'b0;
		while (board.pending_pairs.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (board.failures == 0 && board.pending_pairs.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/aapc_pkg.sv
hw/rtl/aapc_in_if.sv
hw/rtl/aapc_out_if.sv
hw/rtl/aapc_cfg_if.sv
hw/rtl/aapc_ram.sv
hw/rtl/aapc_ctrl.sv
hw/rtl/aapc_dp.sv
hw/rtl/aabb_all_pairs_collision_unit.sv
verif/testbench.sv
